### rtl/core/ipp_pkg.sv
package ipp_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int GROUPS      = 8;
	localparam int GROUP_W     = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_IPV4_ENABLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IPV6_ENABLE = 2'd1;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] CHAR_DOT     = 8'h2E;
	localparam logic [7:0] CHAR_COLON   = 8'h3A;

	localparam logic [7:0] LOWER_HEX_BIAS = 8'h57;
	localparam logic [7:0] UPPER_HEX_BIAS = 8'h37;
	localparam logic [9:0] OCTET_MAX      = 10'd255;

	typedef logic [GROUPS-1:0][GROUP_W-1:0] group_arr_t;

	typedef struct packed {
		logic       ok4;
		logic       ok6;
		logic       gap;
		logic [3:0] gap_pos;
		logic [3:0] count;
		logic [31:0] octets;
		group_arr_t groups;
	} summary_t;

endpackage

### rtl/core/ipp_scan.sv
module ipp_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_code,
	input  logic              last_char,
	output ipp_pkg::summary_t summary
);
	import ipp_pkg::*;

	logic        v4_q, v6_q, gap_q, colon_q;
	logic [9:0]  dec_q;
	logic [31:0] oct_q;
	logic [1:0]  dots_q;
	logic [2:0]  digit_q;
	logic [15:0] hex_q;
	group_arr_t  grp_q;
	logic [3:0]  gcnt_q, gpos_q;

	logic        n_v4, n_v6, n_gap, n_colon;
	logic [9:0]  n_dec;
	logic [31:0] n_oct;
	logic [1:0]  n_dots;
	logic [2:0]  n_digit;
	logic [15:0] n_hex;
	group_arr_t  n_grp;
	logic [3:0]  n_gcnt, n_gpos;

	logic        is_dec, is_hex;
	logic [3:0]  hv;
	logic [13:0] dec_prod;

	always_comb begin
		is_dec = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
		is_hex = 1'b1;
		hv     = '0;
		if (is_dec) begin
			hv = 4'(char_code - CHAR_ZERO);
		end else if ((char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F)) begin
			hv = 4'(char_code - LOWER_HEX_BIAS);
		end else if ((char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F)) begin
			hv = 4'(char_code - UPPER_HEX_BIAS);
		end else begin
			is_hex = 1'b0;
		end
		dec_prod = {4'd0, dec_q} * 14'd10 + {10'd0, hv};
	end

	always_comb begin
		n_v4    = v4_q;
		n_v6    = v6_q;
		n_gap   = gap_q;
		n_colon = colon_q;
		n_dec   = dec_q;
		n_oct   = oct_q;
		n_dots  = dots_q;
		n_digit = digit_q;
		n_hex   = hex_q;
		n_grp   = grp_q;
		n_gcnt  = gcnt_q;
		n_gpos  = gpos_q;
		if (is_hex) begin
			if (!is_dec || (digit_q >= 3'd3)) begin
				n_v4 = 1'b0;
			end else begin
				n_dec = dec_prod[9:0];
			end
			if (colon_q && (gcnt_q == 4'd0) && !gap_q) begin
				n_v6 = 1'b0;
			end
			if (digit_q >= 3'd4) begin
				n_v6 = 1'b0;
			end else begin
				n_hex = {hex_q[11:0], hv};
			end
			n_colon = 1'b0;
			if (digit_q != 3'd7) begin
				n_digit = digit_q + 3'd1;
			end
		end else if (char_code == CHAR_DOT) begin
			n_v6 = 1'b0;
			if ((digit_q == 3'd0) || (dec_q > OCTET_MAX) || (dots_q == 2'd3)) begin
				n_v4 = 1'b0;
			end else begin
				n_oct  = {oct_q[23:0], dec_q[7:0]};
				n_dots = dots_q + 2'd1;
			end
			n_dec   = '0;
			n_digit = '0;
		end else if (char_code == CHAR_COLON) begin
			n_v4 = 1'b0;
			if (colon_q) begin
				if (gap_q) begin
					n_v6 = 1'b0;
				end else begin
					n_gap  = 1'b1;
					n_gpos = gcnt_q;
				end
			end else if (digit_q != 3'd0) begin
				if (gcnt_q >= 4'd8) begin
					n_v6 = 1'b0;
				end else begin
					n_grp[gcnt_q[2:0]] = hex_q;
				end
				if (gcnt_q != 4'd15) begin
					n_gcnt = gcnt_q + 4'd1;
				end
			end
			n_colon = 1'b1;
			n_hex   = '0;
			n_digit = '0;
		end else begin
			n_v4 = 1'b0;
			n_v6 = 1'b0;
		end
	end

	logic [4:0] cnt5;
	logic       ok6f;
	group_arr_t gfin;

	always_comb begin
		cnt5 = {1'b0, n_gcnt};
		ok6f = n_v6;
		gfin = n_grp;
		if (n_digit != 3'd0) begin
			if (n_gcnt >= 4'd8) begin
				ok6f = 1'b0;
			end else begin
				gfin[n_gcnt[2:0]] = n_hex;
			end
			cnt5 = cnt5 + 5'd1;
		end else if (!(n_gap && (n_gpos == n_gcnt))) begin
			ok6f = 1'b0;
		end
		if (n_gap ? (cnt5 > 5'd7) : (cnt5 != 5'd8)) begin
			ok6f = 1'b0;
		end
		summary.ok4     = n_v4 && (n_dots == 2'd3) && (n_digit != 3'd0) && (n_dec <= OCTET_MAX);
		summary.ok6     = ok6f;
		summary.gap     = n_gap;
		summary.gap_pos = n_gpos;
		summary.count   = cnt5[3:0];
		summary.octets  = {n_oct[23:0], n_dec[7:0]};
		summary.groups  = gfin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_q    <= 1'b1;
			v6_q    <= 1'b1;
			gap_q   <= 1'b0;
			colon_q <= 1'b0;
			dec_q   <= '0;
			oct_q   <= '0;
			dots_q  <= '0;
			digit_q <= '0;
			hex_q   <= '0;
			grp_q   <= '0;
			gcnt_q  <= '0;
			gpos_q  <= '0;
		end else if (step) begin
			if (last_char) begin
				v4_q    <= 1'b1;
				v6_q    <= 1'b1;
				gap_q   <= 1'b0;
				colon_q <= 1'b0;
				dec_q   <= '0;
				oct_q   <= '0;
				dots_q  <= '0;
				digit_q <= '0;
				hex_q   <= '0;
				grp_q   <= '0;
				gcnt_q  <= '0;
				gpos_q  <= '0;
			end else begin
				v4_q    <= n_v4;
				v6_q    <= n_v6;
				gap_q   <= n_gap;
				colon_q <= n_colon;
				dec_q   <= n_dec;
				oct_q   <= n_oct;
				dots_q  <= n_dots;
				digit_q <= n_digit;
				hex_q   <= n_hex;
				grp_q   <= n_grp;
				gcnt_q  <= n_gcnt;
				gpos_q  <= n_gpos;
			end
		end
	end

endmodule

### rtl/core/ip_address_text_parser.sv
// Parses an IPv4 dotted decimal or IPv6 colon hex address string that arrives one character
// per word, and on the word flagged as the last character delivers one result word with a
// valid flag, the version and the 128-bit address (IPv4 sits in the low 32 bits). Characters
// are taken at one per cycle while input is not stalled: each goes through an input register
// and then updates the parse state, and the result of a final character passes from the input
// register into the output register. Input is stalled only while a final character waits in
// the input register and the output register still holds a result not yet taken.
module ip_address_text_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [7:0]                       char_code,
	input  logic                             last_char,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic                             addr_valid,
	output logic                             addr_version,
	output logic [63:0]                      addr_high,
	output logic [63:0]                      addr_low,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ipp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic                             cfg_data
);
	import ipp_pkg::*;

	logic       ipv4_en_q, ipv6_en_q;
	logic       valid_s1, last_s1;
	logic [7:0] char_s1;
	logic       advance, produce, out_free;
	summary_t   summary;

	logic        res_valid_q, res_ok_q, res_ver_q;
	logic [63:0] res_high_q, res_low_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipv4_en_q <= 1'b1;
			ipv6_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IPV4_ENABLE: ipv4_en_q <= cfg_data;
				REG_IPV6_ENABLE: ipv6_en_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free   = !res_valid_q || !result_stall;
	assign advance    = valid_s1 && (!last_s1 || out_free);
	assign produce    = advance && last_s1;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	ipp_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_code (char_s1),
		.last_char (last_s1),
		.summary   (summary)
	);

	logic [3:0]  pos, right;
	group_arr_t  full;

	always_comb begin
		logic [3:0] ip;
		logic [4:0] reach;
		logic [3:0] src;
		pos   = summary.gap ? summary.gap_pos : summary.count;
		right = summary.count - pos;
		for (int i = 0; i < GROUPS; i++) begin
			ip    = 4'(i);
			reach = {1'b0, ip} + {1'b0, right};
			src   = pos + ip + right;
			if (ip < pos) begin
				full[GROUPS-1-i] = summary.groups[i];
			end else if (reach >= 5'd8) begin
				full[GROUPS-1-i] = summary.groups[src[2:0]];
			end else begin
				full[GROUPS-1-i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (produce) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			if (ipv4_en_q && summary.ok4) begin
				res_ok_q   <= 1'b1;
				res_ver_q  <= 1'b0;
				res_high_q <= '0;
				res_low_q  <= {32'd0, summary.octets};
			end else if (ipv6_en_q && summary.ok6) begin
				res_ok_q   <= 1'b1;
				res_ver_q  <= 1'b1;
				res_high_q <= full[7:4];
				res_low_q  <= full[3:0];
			end else begin
				res_ok_q   <= 1'b0;
				res_ver_q  <= 1'b0;
				res_high_q <= '0;
				res_low_q  <= '0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign addr_valid   = res_ok_q;
	assign addr_version = res_ver_q;
	assign addr_high    = res_high_q;
	assign addr_low     = res_low_q;

	// Input backs up only behind a final character that finds the result register occupied.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && last_s1 && res_valid_q && result_stall))
		else $error("input stalled without a blocked final character");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !addr_valid) |->
			(!addr_version && (addr_high == 64'd0) && (addr_low == 64'd0)))
		else $error("rejected address carries nonzero fields");

	a_v4_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && addr_valid && !addr_version) |->
			((addr_high == 64'd0) && (addr_low[63:32] == 32'd0)))
		else $error("IPv4 result has bits above the low 32");

endmodule

### sim/tb_ip_address_text_parser.sv
module tb_ip_address_text_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import ipp_pkg::*;

	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam int PHASE_CHARS = 110;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} char_word_t;

	typedef struct packed {
		logic        valid;
		logic        version;
		logic [63:0] high;
		logic [63:0] low;
	} addr_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [7:0] char_code = 8'd0;
	logic last_char = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic addr_valid;
	logic addr_version;
	logic [63:0] addr_high;
	logic [63:0] addr_low;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_IPV4_ENABLE;
	logic cfg_data = 1'b0;

	ip_address_text_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.char_code(char_code),
		.last_char(last_char),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.addr_valid(addr_valid),
		.addr_version(addr_version),
		.addr_high(addr_high),
		.addr_low(addr_low),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	char_word_t pending_chars[$];
	addr_result_t expected_addrs[$];
	logic [7:0] text_buf[$];
	char_word_t next_word;
	int errors = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit send_idling = 1'b0;
	bit recv_idling = 1'b0;

	logic ipv4_on = 1'b1;
	logic ipv6_on = 1'b1;
	logic v4_live;
	logic v6_live;
	logic [9:0] dec_acc;
	logic [31:0] octets;
	logic [2:0] dots;
	logic [15:0] hex_acc;
	logic [2:0] digits;
	logic [15:0] groups [GROUPS];
	logic [3:0] ngroups;
	logic gap_seen;
	logic [3:0] gap_pos;
	logic after_colon;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic restart_parse();
		v4_live = 1'b1;
		v6_live = 1'b1;
		dec_acc = '0;
		octets = '0;
		dots = '0;
		hex_acc = '0;
		digits = '0;
		for (int i = 0; i < GROUPS; i++)
			groups[i] = '0;
		ngroups = '0;
		gap_seen = 1'b0;
		gap_pos = '0;
		after_colon = 1'b0;
	endtask

	task automatic parse_char(input logic [7:0] c, input logic last);
		int hv;
		int cnt;
		int pos;
		int right;
		logic is_dec;
		logic ok4;
		logic ok6;
		logic [15:0] full [GROUPS];
		addr_result_t res;
		is_dec = (c >= CHAR_ZERO && c <= CHAR_NINE);
		hv = -1;
		if (is_dec)
			hv = int'(c - CHAR_ZERO);
		else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
			hv = int'(c - CHAR_LOWER_A) + 10;
		else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
			hv = int'(c - CHAR_UPPER_A) + 10;

		if (hv >= 0) begin
			if (!is_dec || digits >= 3)
				v4_live = 1'b0;
			else
				dec_acc = 10'(int'(dec_acc) * 10 + hv);
			if (after_colon && ngroups == 0 && !gap_seen)
				v6_live = 1'b0;
			if (digits >= 4)
				v6_live = 1'b0;
			else
				hex_acc = {hex_acc[11:0], 4'(hv)};
			after_colon = 1'b0;
			if (digits < 7)
				digits = digits + 3'd1;
		end else if (c == CHAR_DOT) begin
			v6_live = 1'b0;
			if (digits == 0 || dec_acc > OCTET_MAX || dots >= 3) begin
				v4_live = 1'b0;
			end else begin
				octets = {octets[23:0], dec_acc[7:0]};
				dots = dots + 3'd1;
			end
			dec_acc = '0;
			digits = '0;
		end else if (c == CHAR_COLON) begin
			v4_live = 1'b0;
			if (after_colon) begin
				if (gap_seen) begin
					v6_live = 1'b0;
				end else begin
					gap_seen = 1'b1;
					gap_pos = ngroups;
				end
			end else if (digits != 0) begin
				if (ngroups >= GROUPS)
					v6_live = 1'b0;
				else
					groups[ngroups[2:0]] = hex_acc;
				if (ngroups < 15)
					ngroups = ngroups + 4'd1;
			end
			after_colon = 1'b1;
			hex_acc = '0;
			digits = '0;
		end else begin
			v4_live = 1'b0;
			v6_live = 1'b0;
		end

		if (last) begin
			ok4 = v4_live && dots == 3 && digits >= 1 && dec_acc <= OCTET_MAX;
			ok6 = v6_live;
			cnt = int'(ngroups);
			if (digits > 0) begin
				if (cnt >= GROUPS)
					ok6 = 1'b0;
				else
					groups[cnt] = hex_acc;
				cnt++;
			end else if (!(gap_seen && int'(gap_pos) == cnt)) begin
				ok6 = 1'b0;
			end
			if (gap_seen ? (cnt > 7) : (cnt != GROUPS))
				ok6 = 1'b0;

			res = '0;
			if (ipv4_on && ok4) begin
				res.valid = 1'b1;
				res.low = {32'd0, octets[23:0], dec_acc[7:0]};
			end else if (ipv6_on && ok6) begin
				pos = gap_seen ? int'(gap_pos) : cnt;
				right = cnt - pos;
				for (int i = 0; i < GROUPS; i++) begin
					if (i < pos)
						full[i] = groups[i];
					else if (i >= GROUPS - right)
						full[i] = groups[(pos + i - (GROUPS - right)) & 7];
					else
						full[i] = '0;
				end
				res.valid = 1'b1;
				res.version = 1'b1;
				res.high = {full[0], full[1], full[2], full[3]};
				res.low = {full[4], full[5], full[6], full[7]};
			end
			expected_addrs.insert(expected_addrs.size(), res);
			restart_parse();
		end
	endtask

	// A word is taken at an edge with valid high and stall low; the next one is loaded then.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				parse_char(char_code, last_char);
			if (!item_valid || !item_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					item_valid <= 1'b0;
				end else if (send_idling && $urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(0, 5);
					item_valid <= 1'b0;
				end else if (pending_chars.size() != 0) begin
					next_word = pending_chars.pop_front();
					item_valid <= 1'b1;
					char_code <= next_word.code;
					last_char <= next_word.last;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %h, actual %h", name, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		addr_result_t want;
		if (expected_addrs.size() == 0) begin
			$error("Unexpected result: valid %b version %b high %h low %h",
				addr_valid, addr_version, addr_high, addr_low);
			errors++;
		end else begin
			want = expected_addrs.pop_front();
			compare_field("addr_valid", 64'(want.valid), 64'(addr_valid));
			compare_field("addr_version", 64'(want.version), 64'(addr_version));
			compare_field("addr_high", want.high, addr_high);
			compare_field("addr_low", want.low, addr_low);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				check_result();
			if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				result_stall <= 1'b1;
			end else if (recv_idling && $urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(0, 5);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_IPV4_ENABLE)
			ipv4_on = val;
		else if (idx == REG_IPV6_ENABLE)
			ipv6_on = val;
	endtask

	task automatic set_enables(input logic v4, input logic v6);
		write_reg(REG_IPV4_ENABLE, v4);
		write_reg(REG_IPV6_ENABLE, v6);
		write_reg(REG_SPARE, 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending_chars.size() != 0 || item_valid || expected_addrs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic append_char(input logic [7:0] c);
		text_buf.insert(text_buf.size(), c);
	endtask

	task automatic flush_text();
		char_word_t w;
		for (int i = 0; i < text_buf.size(); i++) begin
			w.code = text_buf[i];
			w.last = (i == text_buf.size() - 1);
			pending_chars.insert(pending_chars.size(), w);
		end
		text_buf.delete();
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			append_char(s[i]);
		flush_text();
	endtask

	task automatic add_digits(input int value, input int base, input int count);
		int d;
		for (int i = count - 1; i >= 0; i--) begin
			d = (value / (base ** i)) % base;
			if (d < 10)
				append_char(CHAR_ZERO + 8'(d));
			else if ($urandom_range(0, 1) == 1)
				append_char(CHAR_LOWER_A + 8'(d - 10));
			else
				append_char(CHAR_UPPER_A + 8'(d - 10));
		end
	endtask

	task automatic make_ipv4();
		int v;
		int r;
		int least;
		for (int k = 0; k < 4; k++) begin
			if (k != 0)
				append_char(CHAR_DOT);
			r = $urandom_range(0, 15);
			if (r == 0)
				v = $urandom_range(256, 999);
			else if (r == 1)
				v = 0;
			else if (r == 2)
				v = 255;
			else
				v = $urandom_range(0, 255);
			least = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
			add_digits(v, 10, $urandom_range(least, 3));
		end
	endtask

	task automatic add_group();
		int n;
		int r;
		int v;
		r = $urandom_range(0, 9);
		n = $urandom_range(1, 4);
		if (r == 0) begin
			n = 4;
			v = 16'hFFFF;
		end else if (r == 1) begin
			v = 0;
		end else begin
			v = $urandom_range(0, (1 << (4 * n)) - 1);
		end
		add_digits(v, 16, n);
	endtask

	task automatic make_ipv6_full();
		for (int k = 0; k < GROUPS; k++) begin
			if (k != 0)
				append_char(CHAR_COLON);
			add_group();
		end
	endtask

	task automatic make_ipv6_short();
		int n;
		int pos;
		n = $urandom_range(0, 7);
		pos = $urandom_range(0, n);
		for (int k = 0; k < pos; k++) begin
			add_group();
			if (k < pos - 1)
				append_char(CHAR_COLON);
		end
		append_char(CHAR_COLON);
		append_char(CHAR_COLON);
		for (int k = pos; k < n; k++) begin
			add_group();
			if (k < n - 1)
				append_char(CHAR_COLON);
		end
	endtask

	task automatic mutate_text();
		int at;
		at = $urandom_range(0, text_buf.size() - 1);
		case ($urandom_range(0, 5))
			0: text_buf[at] = 8'($urandom_range(0, 255));
			1: text_buf.insert(at, CHAR_COLON);
			2: text_buf.insert(at, CHAR_DOT);
			3: text_buf.insert(at, CHAR_PERCENT);
			4: if (text_buf.size() > 1) text_buf.delete(at);
			default: text_buf.insert(at, text_buf[at]);
		endcase
	endtask

	task automatic make_noise();
		int n;
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 4))
				0: append_char(CHAR_COLON);
				1: append_char(CHAR_DOT);
				2: append_char(8'($urandom_range(0, 255)));
				default: add_digits($urandom_range(0, 15), 16, 1);
			endcase
		end
	endtask

	task automatic make_address();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			make_ipv4();
		end else if (r < 45) begin
			make_ipv6_full();
		end else if (r < 75) begin
			make_ipv6_short();
		end else if (r < 90) begin
			case ($urandom_range(0, 2))
				0: make_ipv4();
				1: make_ipv6_full();
				default: make_ipv6_short();
			endcase
			mutate_text();
			if ($urandom_range(0, 2) == 0)
				mutate_text();
		end else begin
			make_noise();
		end
	endtask

	task automatic run_random(input int nchars);
		int sent;
		sent = 0;
		while (sent < nchars) begin
			make_address();
			sent += text_buf.size();
			flush_text();
		end
		wait_idle();
	endtask

	initial begin
		string directed[$] = '{
			"0.0.0.0", "255.255.255.255", "010.1.99.200", "256.1.2.3", "1.2.3",
			"1.2.3.4.5", "1234.5.6.7", "0:0:0:0:0:0:0:0",
			"FFFF:ffff:0123:4567:89ab:cdef:ABCD:EF01", "::", "::1", "1::",
			"fe80::a:B:c", "1:2:3:4:5:6:7::", "1:2:3:4:5:6:7:8:9", "1::2::3", ":::",
			":1:2:3:4:5:6:7", "1:2:3:4:5:6:7:", "12345::", "fe80::1%eth0",
			"::ffff:1.2.3.4", "g::1"
		};
		restart_parse();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_idling = 1'b1;
		recv_idling = 1'b1;

		foreach (directed[i])
			queue_text(directed[i]);
		append_char(8'h00);
		flush_text();
		append_char(8'hFF);
		flush_text();
		wait_idle();

		set_enables(1'b0, 1'b1);
		run_random(PHASE_CHARS);
		set_enables(1'b1, 1'b0);
		run_random(PHASE_CHARS);
		set_enables(1'b0, 1'b0);
		run_random(PHASE_CHARS);
		set_enables(1'b1, 1'b1);
		run_random(PHASE_CHARS);
		send_idling = 1'b0;
		recv_idling = 1'b0;
		run_random(PHASE_CHARS);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
